/* sv/ryx_pkg.sv */
// shared types and constants of the rgb to yxy converter
// no dependencies
`default_nettype none

package ryx_pkg;

   localparam int PIX_W   = 8;
   localparam int COEF_W  = 19;
   localparam int TRI_W   = 27;
   localparam int SUM_W   = 29;
   localparam int QUO_W   = 16;
   localparam int LUMA_W  = 19;
   localparam int LUMA_DROP = 8;
   localparam int STEPS_PER_STAGE = 4;

   // cie rgb matrix, q.16 coefficients
   localparam logic [COEF_W-1:0] COEF_XR = 19'd181458;
   localparam logic [COEF_W-1:0] COEF_XG = 19'd114800;
   localparam logic [COEF_W-1:0] COEF_XB = 19'd74065;
   localparam logic [COEF_W-1:0] COEF_YR = 19'd65536;
   localparam logic [COEF_W-1:0] COEF_YG = 19'd300850;
   localparam logic [COEF_W-1:0] COEF_YB = 19'd3937;
   localparam logic [COEF_W-1:0] COEF_ZG = 19'd3703;
   localparam logic [COEF_W-1:0] COEF_ZB = 19'd366620;

   // one item in flight through the divider stages
   typedef struct packed {
      logic [SUM_W-1:0]  rem_x;
      logic [SUM_W-1:0]  rem_y;
      logic [SUM_W-1:0]  sum;
      logic [QUO_W-1:0]  quo_x;
      logic [QUO_W-1:0]  quo_y;
      logic [LUMA_W-1:0] luma;
      logic              black;
   } div_type;

endpackage

`default_nettype wire

/* sv/ryx_matrix.sv */
// matrix stage: rgb to xyz products, then sum and divider setup
// depends on ryx_pkg
`default_nettype none

module ryx_matrix (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic [ryx_pkg::PIX_W-1:0]  red,
   input  wire logic [ryx_pkg::PIX_W-1:0]  green,
   input  wire logic [ryx_pkg::PIX_W-1:0]  blue,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output ryx_pkg::div_type                out_item
);

   logic                         va_ff, va_in;
   logic                         vb_ff, vb_in;
   logic [ryx_pkg::TRI_W-1:0]    x_ff, y_ff, z_ff;
   logic [ryx_pkg::TRI_W-1:0]    x_in, y_in, z_in;
   ryx_pkg::div_type             item_ff, item_in;
   logic                         ready_a, ready_b;
   logic [ryx_pkg::SUM_W-1:0]    sum;

   assign ready_b  = !vb_ff || out_ready;
   assign ready_a  = !va_ff || ready_b;
   assign in_ready = ready_a;

   // tristimulus products with exact sums
   always_comb begin
      x_in = ryx_pkg::TRI_W'(ryx_pkg::COEF_XR) * ryx_pkg::TRI_W'(red)
           + ryx_pkg::TRI_W'(ryx_pkg::COEF_XG) * ryx_pkg::TRI_W'(green)
           + ryx_pkg::TRI_W'(ryx_pkg::COEF_XB) * ryx_pkg::TRI_W'(blue);
      y_in = ryx_pkg::TRI_W'(ryx_pkg::COEF_YR) * ryx_pkg::TRI_W'(red)
           + ryx_pkg::TRI_W'(ryx_pkg::COEF_YG) * ryx_pkg::TRI_W'(green)
           + ryx_pkg::TRI_W'(ryx_pkg::COEF_YB) * ryx_pkg::TRI_W'(blue);
      z_in = ryx_pkg::TRI_W'(ryx_pkg::COEF_ZG) * ryx_pkg::TRI_W'(green)
           + ryx_pkg::TRI_W'(ryx_pkg::COEF_ZB) * ryx_pkg::TRI_W'(blue);
   end

   // sum and divider seed
   always_comb begin
      sum = ryx_pkg::SUM_W'(x_ff) + ryx_pkg::SUM_W'(y_ff) + ryx_pkg::SUM_W'(z_ff);
      item_in.rem_x = ryx_pkg::SUM_W'(x_ff);
      item_in.rem_y = ryx_pkg::SUM_W'(y_ff);
      item_in.sum   = sum;
      item_in.quo_x = '0;
      item_in.quo_y = '0;
      item_in.luma  = y_ff[ryx_pkg::TRI_W-1:ryx_pkg::LUMA_DROP];
      item_in.black = (sum == '0);
   end

   assign va_in = ready_a ? in_valid : va_ff;
   assign vb_in = ready_b ? va_ff : vb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
      if (ready_b) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

/* sv/ryx_div_stage.sv */
// one divider stage: four restoring steps for both chromaticities
// depends on ryx_pkg
`default_nettype none

module ryx_div_stage (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire ryx_pkg::div_type in_item,
   output logic            out_valid,
   input  wire logic       out_ready,
   output ryx_pkg::div_type out_item
);

   logic             valid_ff, valid_in;
   ryx_pkg::div_type item_ff, item_in;

   assign in_ready = !valid_ff || out_ready;

   // shift, compare and subtract, one quotient bit per step
   always_comb begin
      logic [ryx_pkg::SUM_W:0] tx, ty;
      item_in = in_item;
      for (int i = 0; i < ryx_pkg::STEPS_PER_STAGE; i++) begin
         tx = {item_in.rem_x, 1'b0};
         ty = {item_in.rem_y, 1'b0};
         if (tx >= {1'b0, item_in.sum}) begin
            item_in.rem_x = ryx_pkg::SUM_W'(tx - {1'b0, item_in.sum});
            item_in.quo_x = {item_in.quo_x[ryx_pkg::QUO_W-2:0], 1'b1};
         end else begin
            item_in.rem_x = tx[ryx_pkg::SUM_W-1:0];
            item_in.quo_x = {item_in.quo_x[ryx_pkg::QUO_W-2:0], 1'b0};
         end
         if (ty >= {1'b0, item_in.sum}) begin
            item_in.rem_y = ryx_pkg::SUM_W'(ty - {1'b0, item_in.sum});
            item_in.quo_y = {item_in.quo_y[ryx_pkg::QUO_W-2:0], 1'b1};
         end else begin
            item_in.rem_y = ty[ryx_pkg::SUM_W-1:0];
            item_in.quo_y = {item_in.quo_y[ryx_pkg::QUO_W-2:0], 1'b0};
         end
      end
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

/* sv/rgb_to_yxy_converter.sv */
// top level of the rgb to yxy converter
// depends on ryx_pkg, ryx_matrix, ryx_div_stage
`default_nettype none

// Converts one 8-bit RGB pixel per cycle into luma Y (8 fractional bits) and
// chromaticities x, y (unsigned Q0.16, truncated). Each result passes
// through seven registers: two matrix stages, four divider stages of four
// restoring steps each (16 quotient bits), and the output register.
// Throughput is one item per cycle when the output is not stalled; the
// dividers are fully pipelined, and each stage advances on its own, so
// bubbles close up under a stalled output.
// A black pixel gives black_pixel = 1 with x = y = 0.

module rgb_to_yxy_converter (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [ryx_pkg::PIX_W-1:0]   req_red,
   input  wire logic [ryx_pkg::PIX_W-1:0]   req_green,
   input  wire logic [ryx_pkg::PIX_W-1:0]   req_blue,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [ryx_pkg::LUMA_W-1:0]       rsp_luma_y,
   output logic [ryx_pkg::QUO_W-1:0]        rsp_chroma_x,
   output logic [ryx_pkg::QUO_W-1:0]        rsp_chroma_y,
   output logic                             rsp_black_pixel
);

   localparam int NUM_DIV = ryx_pkg::QUO_W / ryx_pkg::STEPS_PER_STAGE;

   logic             valid   [NUM_DIV+1];
   logic             ready   [NUM_DIV+1];
   ryx_pkg::div_type item    [NUM_DIV+1];
   logic             out_ready;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ryx_pkg::LUMA_W-1:0] luma_ff;
   logic [ryx_pkg::QUO_W-1:0]  cx_ff, cy_ff;
   logic                       black_ff;

   ryx_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .out_valid (valid[0]),
      .out_ready (ready[0]),
      .out_item  (item[0])
   );

   // divider pipeline
   for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
      ryx_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[g]),
         .in_ready  (ready[g]),
         .in_item   (item[g]),
         .out_valid (valid[g+1]),
         .out_ready (ready[g+1]),
         .out_item  (item[g+1])
      );
   end

   // output register, chromaticities forced to zero on black
   assign out_ready      = !rsp_valid_ff || rsp_ready;
   assign ready[NUM_DIV] = out_ready;
   assign rsp_valid_in   = out_ready ? valid[NUM_DIV] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         luma_ff  <= item[NUM_DIV].luma;
         cx_ff    <= item[NUM_DIV].black ? '0 : item[NUM_DIV].quo_x;
         cy_ff    <= item[NUM_DIV].black ? '0 : item[NUM_DIV].quo_y;
         black_ff <= item[NUM_DIV].black;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_luma_y      = luma_ff;
   assign rsp_chroma_x    = cx_ff;
   assign rsp_chroma_y    = cy_ff;
   assign rsp_black_pixel = black_ff;

   // black pixel gives all-zero fields
   a_black_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_black_pixel |->
         rsp_chroma_x == '0 && rsp_chroma_y == '0 && rsp_luma_y == '0)
      else $error("black item with nonzero fields");

   // x + y stays at or below one
   a_chroma_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_black_pixel |->
         ({1'b0, rsp_chroma_x} + {1'b0, rsp_chroma_y}) <= 17'h10000)
      else $error("chromaticity sum above one");

   // a lit pixel always has some luma
   a_luma_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_black_pixel |-> rsp_luma_y != '0)
      else $error("lit item with zero luma");

endmodule

`default_nettype wire

/* sim/rgb_to_yxy_converter_tb.sv */
// testbench for the rgb to yxy converter: random and directed pixels, scoreboard check
// depends on ryx_pkg and rgb_to_yxy_converter
`default_nettype none

module rgb_to_yxy_converter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 5000;
   localparam int LATENCY = 7;

   // expected yxy form of one pixel
   typedef struct {
      logic [ryx_pkg::LUMA_W-1:0] luma;
      logic [ryx_pkg::QUO_W-1:0]  cx;
      logic [ryx_pkg::QUO_W-1:0]  cy;
      logic                       black;
   } yxy_type;

   // scoreboard: predicts the yxy form of each accepted pixel and checks results
   class yxy_scoreboard;
      yxy_type pending[$];
      int mismatches;
      int checked;

      function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         logic [63:0] tx, ty, tz, s, q;
         yxy_type e;
         tx = 64'(ryx_pkg::COEF_XR) * r + 64'(ryx_pkg::COEF_XG) * g
            + 64'(ryx_pkg::COEF_XB) * b;
         ty = 64'(ryx_pkg::COEF_YR) * r + 64'(ryx_pkg::COEF_YG) * g
            + 64'(ryx_pkg::COEF_YB) * b;
         tz = 64'(ryx_pkg::COEF_ZG) * g + 64'(ryx_pkg::COEF_ZB) * b;
         s = tx + ty + tz;
         e.luma = ryx_pkg::LUMA_W'(ty >> ryx_pkg::LUMA_DROP);
         e.black = (s == 0);
         if (s == 0) begin
            e.cx = '0;
            e.cy = '0;
         end else begin
            q = (tx << 16) / s;
            e.cx = (q > 65535) ? 16'hFFFF : q[15:0];
            q = (ty << 16) / s;
            e.cy = (q > 65535) ? 16'hFFFF : q[15:0];
         end
         pending.push_back(e);
      endfunction

      function void check_result(logic [ryx_pkg::LUMA_W-1:0] l,
                                 logic [ryx_pkg::QUO_W-1:0] x,
                                 logic [ryx_pkg::QUO_W-1:0] y, logic k);
         yxy_type e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result luma=%0d", l);
            return;
         end
         e = pending.pop_front();
         if (e.luma !== l || e.cx !== x || e.cy !== y || e.black !== k) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp Y=%0d x=%0d y=%0d blk=%0b got Y=%0d x=%0d y=%0d blk=%0b",
                        e.luma, e.cx, e.cy, e.black, l, x, y, k);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [7:0] req_red = 0, req_green = 0, req_blue = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [ryx_pkg::LUMA_W-1:0] rsp_luma_y;
   logic [ryx_pkg::QUO_W-1:0] rsp_chroma_x, rsp_chroma_y;
   logic rsp_black_pixel;

   yxy_scoreboard board = new();
   int idle_cycles = 0;
   int sent = 0;
   bit timed_out = 0;

   rgb_to_yxy_converter uut (.*);

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // receiver stall pattern: phases of full flow, heavy and light stalling
   int stall_mode = 0;
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // result check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_luma_y, rsp_chroma_x, rsp_chroma_y, rsp_black_pixel);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // present one pixel and wait for it to be accepted
   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      req_valid <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      do @(posedge clock); while (!req_ready);
      board.note_pixel(r, g, b);
      sent++;
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int burst;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: black, primaries, extremes, single bits
      send_pixel(0, 0, 0);
      send_pixel(255, 255, 255);
      send_pixel(255, 0, 0);
      send_pixel(0, 255, 0);
      send_pixel(0, 0, 255);
      send_pixel(1, 0, 0);
      send_pixel(0, 1, 0);
      send_pixel(0, 0, 1);
      send_pixel(255, 255, 0);
      send_pixel(0, 255, 255);
      send_pixel(255, 0, 255);
      send_pixel(128, 64, 32);
      send_pixel(0, 0, 0);
      send_pixel(170, 85, 170);
      send_pixel(85, 170, 85);
      drop_valid();

      // pause until the pipeline is empty
      wait_drained();

      // random bursts with gaps; black pixels now and then
      while (sent < 615) begin
         burst = $urandom_range(1, 20);
         repeat (burst) begin
            if ($urandom_range(0, 30) == 0) send_pixel(0, 0, 0);
            else send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      drop_valid();
      wait_drained();
      repeat (LATENCY + 5) @(posedge clock);

      $display("run covered %0d pixels incl. black and saturated primaries, %0d results checked",
               sent, board.checked);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // watchdog
   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("watchdog: no progress for %0d cycles", idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule

`default_nettype wire
